/* hdl/bol_pkg.sv */
// Package for the bounded ordered list: sizes, command and status codes,
// and the control bundle broadcast to the storage cells. No dependencies.
`timescale 1ns / 1ps

package bol_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int POS_W = 4;
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [2:0] {
        CMD_APPEND    = 3'd0,
        CMD_POP_FRONT = 3'd1,
        CMD_POP_BACK  = 3'd2,
        CMD_REMOVE_AT = 3'd3,
        CMD_SEARCH    = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // Broadcast to every cell in the cycle of a beat.
    typedef struct packed {
        logic                         load;   // append this beat
        logic                         shift;  // close a gap this beat
        logic [IDX_W-1:0]             base;   // first cell that takes its neighbor
        logic [CNT_W-1:0]             count;  // entries before this beat
        logic signed [DATA_WIDTH-1:0] word;   // word to append or match
    } cell_ctrl_t;

endpackage

/* hdl/bol_cell.sv */
// One storage cell of the ordered list: holds one entry, loads, shifts
// from its upper neighbor, and compares against the search word. Uses bol_pkg.
`timescale 1ns / 1ps

module bol_cell
    import bol_pkg::*;
(
    input  logic                         aclk,
    input  logic [IDX_W-1:0]             cell_index,
    input  cell_ctrl_t                   ctrl,
    input  logic signed [DATA_WIDTH-1:0] nbr_entry,
    output logic signed [DATA_WIDTH-1:0] entry,
    output logic                         match
);

    logic signed [DATA_WIDTH-1:0] entry_reg;
    logic signed [DATA_WIDTH-1:0] entry_next;
    logic                         load_me;
    logic                         shift_me;
    logic                         live;

    assign live     = CNT_W'(cell_index) < ctrl.count;
    assign load_me  = ctrl.load && (CNT_W'(cell_index) == ctrl.count);
    assign shift_me = ctrl.shift && (cell_index >= ctrl.base);

    always_comb begin
        entry_next = entry_reg;
        if (shift_me) begin
            entry_next = nbr_entry;
        end else if (load_me) begin
            entry_next = ctrl.word;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign match = live && (entry_reg == ctrl.word);

endmodule

/* hdl/bol_find.sv */
// Priority encoder over the cell match flags: lowest matching index wins.
// Uses bol_pkg.
`timescale 1ns / 1ps

module bol_find
    import bol_pkg::*;
(
    input  logic [DEPTH-1:0] match,
    output logic             hit,
    output logic [IDX_W-1:0] hit_index
);

    always_comb begin
        hit       = 1'b0;
        hit_index = '0;
        // scan from the top so the lowest match is written last
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit       = 1'b1;
                hit_index = IDX_W'(i);
            end
        end
    end

endmodule

/* hdl/bounded_ordered_list.sv */
// Top level of the bounded ordered list: command decode, entry count,
// result register, and the row of bol_cell storage cells. Uses bol_pkg,
// bol_cell and bol_find.
`timescale 1ns / 1ps

// Bounded ordered list of signed words, front at index 0.
//
// Input channel (s_valid/s_ready): one command per beat with s_command,
// s_value and s_position. Commands: append at the back, pop front (returns
// the word), pop back, remove at position (later entries move up one cell),
// search for the first index holding s_value.
// Result channel (m_valid/m_ready): exactly one beat per command, carrying
// m_popped_value, m_found_index (-1 when absent), m_status and
// m_entry_count (entries after the command).
//
// Throughput: one command per cycle while no result is stalled. Each cell
// loads, shifts from its upper neighbor or holds within the cycle of the
// beat, and every cell compares its entry with the search word in
// parallel, so the list is up to date for the next beat. The result is
// loaded into the output register and appears in the cycle after the input beat.
// Stall: while a result waits with m_ready low, s_ready stays low; it rises
// again in the cycle m_ready takes the waiting beat.
// Reset (aresetn low, synchronous): the list is empty and no result is
// pending. Cell contents are not cleared; a cell is read only after append.

module bounded_ordered_list
    import bol_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_command,
    input  logic signed [31:0] s_value,
    input  logic [3:0]         s_position,

    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_popped_value,
    output logic signed [4:0]  m_found_index,
    output logic [1:0]         m_status,
    output logic [4:0]         m_entry_count
);

    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;

    logic                         m_valid_reg;
    logic                         m_valid_next;
    logic signed [31:0]           popped_reg;
    logic signed [31:0]           popped_next;
    logic signed [4:0]            found_reg;
    logic signed [4:0]            found_next;
    status_t                      status_reg;
    status_t                      status_next;

    logic                         accept;
    logic                         is_empty;
    logic                         is_full;
    logic                         pos_bad;
    cell_ctrl_t                   ctrl;

    logic signed [DATA_WIDTH-1:0] cell_entry [DEPTH];
    logic [DEPTH-1:0]             cell_match;
    logic                         hit;
    logic [IDX_W-1:0]             hit_index;

    // Take a new beat whenever the output register is free or draining.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign pos_bad  = CMP_W'(s_position) >= CMP_W'(count_reg);

    // Decode the command into cell control and the result fields.
    always_comb begin
        ctrl.load   = 1'b0;
        ctrl.shift  = 1'b0;
        ctrl.base   = '0;
        ctrl.count  = count_reg;
        ctrl.word   = DATA_WIDTH'(s_value);

        count_next  = count_reg;
        popped_next = '0;
        found_next  = '1;
        status_next = ST_OK;

        case (cmd_t'(s_command))
            CMD_APPEND: begin
                if (is_full) begin
                    status_next = ST_FULL;
                end else begin
                    ctrl.load  = accept;
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_POP_FRONT: begin
                if (is_empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    // drop the front: every cell takes its neighbor
                    ctrl.shift  = accept;
                    popped_next = 32'(cell_entry[0]);
                    count_next  = count_reg - 1'b1;
                end
            end
            CMD_POP_BACK: begin
                if (is_empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    count_next = count_reg - 1'b1;
                end
            end
            CMD_REMOVE_AT: begin
                if (is_empty) begin
                    status_next = ST_EMPTY;
                end else if (pos_bad) begin
                    status_next = ST_RANGE;
                end else begin
                    // close the gap from the removed cell upward
                    ctrl.shift = accept;
                    ctrl.base  = IDX_W'(s_position);
                    count_next = count_reg - 1'b1;
                end
            end
            CMD_SEARCH: begin
                if (hit) begin
                    found_next = 5'(hit_index);
                end
            end
            default: begin
                // unused codes leave the list alone
            end
        endcase
    end

    // Row of cells; the top cell has no upper neighbor and holds itself.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic signed [DATA_WIDTH-1:0] nbr;
        if (i == DEPTH - 1) begin : g_top
            assign nbr = cell_entry[i];
        end else begin : g_mid
            assign nbr = cell_entry[i + 1];
        end

        bol_cell u_cell (
            .aclk       (aclk),
            .cell_index (IDX_W'(i)),
            .ctrl       (ctrl),
            .nbr_entry  (nbr),
            .entry      (cell_entry[i]),
            .match      (cell_match[i])
        );
    end

    bol_find u_find (
        .match     (cell_match),
        .hit       (hit),
        .hit_index (hit_index)
    );

    // Hold the result until taken; load a new one on each accepted beat.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            popped_reg <= popped_next;
            found_reg  <= found_next;
            status_reg <= status_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_popped_value = popped_reg;
    assign m_found_index  = found_reg;
    assign m_status       = status_reg;
    assign m_entry_count  = 5'(count_reg);

    // The count never runs past the number of cells.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    // Every accepted beat produces a result beat in the next cycle.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("no result after accepted beat");

    // Append to a full list flags full and leaves the count alone.
    a_full_append: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_command == CMD_APPEND) && is_full)
        |=> (m_status == ST_FULL) && (count_reg == CNT_W'(DEPTH)))
        else $error("append to full list misreported");

    // A successful pop front takes exactly one entry.
    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_command == CMD_POP_FRONT) && !is_empty)
        |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("pop front count slip");

endmodule
